FILE: design/lbbt_pkg.sv
// shared types and constants of the label bounding box table
package lbbt_pkg;

  localparam int unsigned LabelW    = 8;
  localparam int unsigned CoordW    = 10;
  localparam int unsigned NumLabels = 255;
  localparam int unsigned AddrW     = $clog2(NumLabels);

  // labels that never own a box
  localparam logic [LabelW-1:0] LabelBackground = LabelW'(0);
  localparam logic [LabelW-1:0] LabelWall       = LabelW'(255);

  // operation codes
  localparam logic OpAccumulate = 1'b0;
  localparam logic OpReport     = 1'b1;

  // input word
  typedef struct packed {
    logic              operation;
    logic [LabelW-1:0] label;
    logic [CoordW-1:0] column;
    logic [CoordW-1:0] row;
  } in_word_t;

  // output word
  typedef struct packed {
    logic              room_found;
    logic [CoordW-1:0] min_column;
    logic [CoordW-1:0] min_row;
    logic [CoordW-1:0] max_column;
    logic [CoordW-1:0] max_row;
    logic [CoordW-1:0] center_column;
    logic [CoordW-1:0] center_row;
  } out_word_t;

  // one table entry
  typedef struct packed {
    logic [CoordW-1:0] min_column;
    logic [CoordW-1:0] max_column;
    logic [CoordW-1:0] min_row;
    logic [CoordW-1:0] max_row;
  } box_t;

  localparam int unsigned BoxW = $bits(box_t);

  // value of an entry that holds no pixel
  localparam box_t BoxEmpty = '{
    min_column: {CoordW{1'b1}},
    max_column: '0,
    min_row:    {CoordW{1'b1}},
    max_row:    '0
  };

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic commit_acc;
    logic commit_rep;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_report;
    logic out_free;
  } dp_status_t;

endpackage

FILE: design/lbbt_if.sv
// valid/ready channel interfaces for input and output words
interface lbbt_in_if
  import lbbt_pkg::*;
  (input logic clk_i);
  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lbbt_out_if
  import lbbt_pkg::*;
  (input logic clk_i);
  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: design/lbbt_ram.sv
// generic single-port-write ram with registered read
module lbbt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, held when idle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/lbbt_ctrl.sv
// controller: accepts one word, then commits it
module lbbt_ctrl
  import lbbt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t sts_i,
  output ctrl_cmd_t  cmd_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StExec = 1'b1;

  logic state_q, state_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = StExec;
        end
      end
      StExec: begin
        if (!sts_i.is_report) begin
          cmd_o.commit_acc = 1'b1;
          state_d          = StIdle;
        end else if (sts_i.out_free) begin
          cmd_o.commit_rep = 1'b1;
          state_d          = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: design/lbbt_dp.sv
// datapath: item register, box table, seen bits and output register
module lbbt_dp
  import lbbt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  in_word_t   in_word_i,
  input  ctrl_cmd_t  cmd_i,
  output dp_status_t sts_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_word_t  out_word_o
);

  in_word_t              item_q;
  logic [NumLabels-1:0]  seen_q, seen_d;
  out_word_t             out_q, out_d;
  logic                  out_valid_q, out_valid_d;
  box_t                  ram_rdata, box_cur, box_new;
  logic                  rd_en, item_in_range, acc_ok, seen_hit, found;
  logic [CoordW-1:0]     span_c, span_r;

  // item register
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_word_i;
    end
  end

  // table read at accept time
  assign rd_en = cmd_i.capture && (in_word_i.label < LabelW'(NumLabels));

  lbbt_ram #(
    .Width (BoxW),
    .Depth (NumLabels)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit_acc && acc_ok),
    .waddr_i (item_q.label[AddrW-1:0]),
    .wdata_i (box_new),
    .re_i    (rd_en),
    .raddr_i (in_word_i.label[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  // entry lookup, an unseen label reads as empty
  assign item_in_range = item_q.label < LabelW'(NumLabels);
  assign acc_ok   = item_in_range && (item_q.label != LabelBackground)
                    && (item_q.label != LabelWall);
  assign seen_hit = item_in_range ? seen_q[item_q.label[AddrW-1:0]] : 1'b0;
  assign box_cur  = seen_hit ? ram_rdata : BoxEmpty;

  // widen the box by the pixel
  always_comb begin
    box_new = box_cur;
    if (item_q.column < box_cur.min_column) box_new.min_column = item_q.column;
    if (item_q.column > box_cur.max_column) box_new.max_column = item_q.column;
    if (item_q.row < box_cur.min_row) box_new.min_row = item_q.row;
    if (item_q.row > box_cur.max_row) box_new.max_row = item_q.row;
  end

  // report word with centres
  assign found  = seen_hit && (box_cur.max_column != '0) && (box_cur.max_row != '0);
  assign span_c = box_cur.max_column - box_cur.min_column;
  assign span_r = box_cur.max_row - box_cur.min_row;

  always_comb begin
    out_d = '0;
    if (found) begin
      out_d.room_found    = 1'b1;
      out_d.min_column    = box_cur.min_column;
      out_d.min_row       = box_cur.min_row;
      out_d.max_column    = box_cur.max_column;
      out_d.max_row       = box_cur.max_row;
      out_d.center_column = box_cur.min_column + (span_c >> 1);
      out_d.center_row    = box_cur.min_row + (span_r >> 1);
    end
  end

  // seen bits: set on accumulate, cleared on report
  always_comb begin
    seen_d = seen_q;
    if (cmd_i.commit_acc && acc_ok) begin
      seen_d[item_q.label[AddrW-1:0]] = 1'b1;
    end else if (cmd_i.commit_rep && item_in_range) begin
      seen_d[item_q.label[AddrW-1:0]] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
    end else begin
      seen_q <= seen_d;
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.commit_rep) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit_rep) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_word_o      = out_q;
  assign sts_o.is_report = (item_q.operation == OpReport);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

endmodule

FILE: design/label_bounding_box_table_unit.sv
// top level of the label bounding box table
//
//   channel  dir  payload       accepted when
//   in_i     in   in_word_t     in_i.valid && in_i.ready
//   out_o    out  out_word_t    out_o.valid && out_o.ready
//
// each word is accepted with a table read, then committed
// (table write for a pixel, output register load for a report); the
// registered read of the box table is why the commit comes after the accept
// a report waits in its commit cycle while the output register is full
// reset clears the seen bits at once, so every label starts empty and the
// table ram needs no clearing pass
module label_bounding_box_table_unit
  import lbbt_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  lbbt_in_if.sink    in_i,
  lbbt_out_if.source out_o
);

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  lbbt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lbbt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_i.data),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_word_o  (out_o.data)
  );

endmodule

FILE: design/lbbt_checker.sv
// port-level checks of the label bounding box table
module lbbt_checker
  import lbbt_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_i,
  input in_word_t  in_data_i,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_word_t out_data_i
);

  // a stalled output word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("output word dropped or changed while stalled");

  // one word at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second word accepted while busy");

  // a pixel word never raises an output word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_data_i.operation == OpAccumulate) && !out_valid_i
    |=> !out_valid_i)
    else $error("output word from a pixel");

  // a missing box reports all zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.room_found |->
    (out_data_i.min_column == '0) && (out_data_i.max_column == '0) &&
    (out_data_i.min_row == '0) && (out_data_i.max_row == '0) &&
    (out_data_i.center_column == '0) && (out_data_i.center_row == '0))
    else $error("empty report with nonzero fields");

  // a found box is ordered and holds its centre
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.room_found |->
    (out_data_i.min_column <= out_data_i.center_column) &&
    (out_data_i.center_column <= out_data_i.max_column) &&
    (out_data_i.min_row <= out_data_i.center_row) &&
    (out_data_i.center_row <= out_data_i.max_row))
    else $error("box out of order");

endmodule

bind label_bounding_box_table_unit lbbt_checker u_lbbt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_data_i   (in_i.data),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
